// ----- rtl/dfm_pkg.sv -----
// Package: shared types and constants of the drain fault monitor.
`timescale 1ns / 1ps
package dfm_pkg;

  localparam int MODE_W   = 1;
  localparam int PERIOD_W = 16;
  localparam int FREQ_W   = 18;
  localparam int CFG_W    = 20;
  localparam int TIMER_W  = 21;
  localparam int CNT_W    = 8;
  localparam int FAIL_W   = 3;
  localparam int CFG_IDX_W = 3;

  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = 1;
  localparam int Q_CNT_W = 2;

  localparam logic [MODE_W-1:0] MODE_DRAIN = 1'b0;
  localparam logic [MODE_W-1:0] MODE_SPIN  = 1'b1;

  localparam logic [FAIL_W-1:0] FAIL_NONE       = 3'd0;
  localparam logic [FAIL_W-1:0] FAIL_BLOCKED    = 3'd1;
  localparam logic [FAIL_W-1:0] FAIL_LOW_RATE   = 3'd2;
  localparam logic [FAIL_W-1:0] FAIL_SPIN_WATER = 3'd3;
  localparam logic [FAIL_W-1:0] FAIL_SPIN_DANGER = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_BLOCKED_TIMEOUT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE_WINDOW     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RISE_LOW        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RISE_HIGH       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPIN_TIMEOUT    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SPIN_DANGER     = 3'd5;

  localparam logic [CFG_W-1:0]  RST_BLOCKED_TIMEOUT = 20'd900000;
  localparam logic [CFG_W-1:0]  RST_RATE_WINDOW     = 20'd180000;
  localparam logic [FREQ_W-1:0] RST_RISE_LOW        = '0;
  localparam logic [FREQ_W-1:0] RST_RISE_HIGH       = '0;
  localparam logic [CFG_W-1:0]  RST_SPIN_TIMEOUT    = 20'd10000;
  localparam logic [CNT_W-1:0]  RST_SPIN_DANGER     = 8'd5;

  // tick class decided by the front end
  typedef enum logic [1:0] {
    OP_DRAIN_CLEAR,
    OP_DRAIN_RUN,
    OP_SPIN_CLEAR,
    OP_SPIN_RUN
  } op_t;

  typedef struct packed {
    op_t                 op;
    logic [PERIOD_W-1:0] period;
    logic [FREQ_W-1:0]   freq;
  } cmd_t;

endpackage

// ----- rtl/dfm_front.sv -----
// Front end: accepts ticks, classifies them and queues commands for the back end.
`timescale 1ns / 1ps
module dfm_front
  import dfm_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [MODE_W-1:0]   in_mode,
  input  logic [PERIOD_W-1:0] in_period_ms,
  input  logic                in_level_flag,
  input  logic [FREQ_W-1:0]   in_level_freq,
  output logic                q_valid,
  output cmd_t                q_cmd,
  input  logic                q_pop
);

  cmd_t                q_mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0]  count_r, count_nxt;
  logic                push;
  cmd_t                cmd_in;

  assign in_stall = (count_r == Q_CNT_W'(Q_DEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count_r != '0);
  assign q_cmd    = q_mem_r[rd_ptr_r];

  always_comb begin
    if (in_mode == MODE_SPIN) begin
      cmd_in.op = in_level_flag ? OP_SPIN_CLEAR : OP_SPIN_RUN;
    end else begin
      cmd_in.op = in_level_flag ? OP_DRAIN_RUN : OP_DRAIN_CLEAR;
    end
    cmd_in.period = in_period_ms;
    cmd_in.freq   = in_level_freq;
  end

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = q_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    case ({push, q_pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= cmd_in;
    end
  end

  a_q_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= Q_CNT_W'(Q_DEPTH))
    else $error("command queue overfilled");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && count_r == Q_CNT_W'(1) && !push) |=> !q_valid)
    else $error("queue not empty after last command taken");

endmodule

// ----- rtl/dfm_back.sv -----
// Back end: configuration registers, supervision timers and result register.
`timescale 1ns / 1ps
module dfm_back
  import dfm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 q_valid,
  input  cmd_t                 q_cmd,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [FAIL_W-1:0]    out_failure_code
);

  logic [CFG_W-1:0]   blocked_timeout_r;
  logic [CFG_W-1:0]   rate_window_r;
  logic [FREQ_W-1:0]  rise_low_r;
  logic [FREQ_W-1:0]  rise_high_r;
  logic [CFG_W-1:0]   spin_timeout_r;
  logic [CNT_W-1:0]   spin_danger_r;

  logic [TIMER_W-1:0] blocked_timer_r, blocked_timer_nxt;
  logic [TIMER_W-1:0] window_timer_r, window_timer_nxt;
  logic [FREQ_W-1:0]  start_freq_r, start_freq_nxt;
  logic [TIMER_W-1:0] spin_timer_r, spin_timer_nxt;
  logic [CNT_W-1:0]   spin_cnt_r, spin_cnt_nxt;
  logic [FAIL_W-1:0]  fail_r, fail_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [FAIL_W-1:0]  out_code_r;

  logic               back_ready;
  logic [TIMER_W-1:0] blk_sum, win_sum, spin_sum;
  logic [FREQ_W-1:0]  start_eff, rise;
  logic [CNT_W-1:0]   cnt_inc;

  assign back_ready       = !out_valid_r || !out_stall;
  assign q_pop            = q_valid && back_ready;
  assign out_valid        = out_valid_r;
  assign out_failure_code = out_code_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blocked_timeout_r <= RST_BLOCKED_TIMEOUT;
      rate_window_r     <= RST_RATE_WINDOW;
      rise_low_r        <= RST_RISE_LOW;
      rise_high_r       <= RST_RISE_HIGH;
      spin_timeout_r    <= RST_SPIN_TIMEOUT;
      spin_danger_r     <= RST_SPIN_DANGER;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BLOCKED_TIMEOUT: blocked_timeout_r <= cfg_data;
        CFG_RATE_WINDOW:     rate_window_r     <= cfg_data;
        CFG_RISE_LOW:        rise_low_r        <= cfg_data[FREQ_W-1:0];
        CFG_RISE_HIGH:       rise_high_r       <= cfg_data[FREQ_W-1:0];
        CFG_SPIN_TIMEOUT:    spin_timeout_r    <= cfg_data;
        CFG_SPIN_DANGER:     spin_danger_r     <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    blk_sum   = blocked_timer_r + TIMER_W'(q_cmd.period);
    win_sum   = window_timer_r + TIMER_W'(q_cmd.period);
    spin_sum  = spin_timer_r + TIMER_W'(q_cmd.period);
    // a fresh window samples the current frequency as its baseline
    start_eff = (window_timer_r == '0) ? q_cmd.freq : start_freq_r;
    rise      = q_cmd.freq - start_eff;
    cnt_inc   = spin_cnt_r + 1'b1;
  end

  always_comb begin
    blocked_timer_nxt = blocked_timer_r;
    window_timer_nxt  = window_timer_r;
    start_freq_nxt    = start_freq_r;
    spin_timer_nxt    = spin_timer_r;
    spin_cnt_nxt      = spin_cnt_r;
    fail_nxt          = fail_r;
    if (q_pop) begin
      unique case (q_cmd.op)
        OP_DRAIN_CLEAR: begin
          blocked_timer_nxt = '0;
          window_timer_nxt  = '0;
        end
        OP_DRAIN_RUN: begin
          if (blk_sum >= TIMER_W'(blocked_timeout_r)) begin
            blocked_timer_nxt = '0;
            fail_nxt          = FAIL_BLOCKED;
          end else begin
            blocked_timer_nxt = blk_sum;
          end
          start_freq_nxt = start_eff;
          if (win_sum > TIMER_W'(rate_window_r)) begin
            window_timer_nxt = '0;
            // low rate wins over a blocked code from the same tick
            if (q_cmd.freq > start_eff && rise > rise_low_r && rise <= rise_high_r) begin
              fail_nxt = FAIL_LOW_RATE;
            end
          end else begin
            window_timer_nxt = win_sum;
          end
        end
        OP_SPIN_CLEAR: begin
          spin_timer_nxt = '0;
          spin_cnt_nxt   = '0;
        end
        OP_SPIN_RUN: begin
          if (spin_sum >= TIMER_W'(spin_timeout_r)) begin
            spin_timer_nxt = '0;
            if (cnt_inc >= spin_danger_r) begin
              spin_cnt_nxt = '0;
              fail_nxt     = FAIL_SPIN_DANGER;
            end else begin
              spin_cnt_nxt = cnt_inc;
              fail_nxt     = FAIL_SPIN_WATER;
            end
          end else begin
            spin_timer_nxt = spin_sum;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid_nxt = back_ready ? q_valid : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blocked_timer_r <= '0;
      window_timer_r  <= '0;
      start_freq_r    <= '0;
      spin_timer_r    <= '0;
      spin_cnt_r      <= '0;
      fail_r          <= FAIL_NONE;
      out_valid_r     <= 1'b0;
    end else begin
      blocked_timer_r <= blocked_timer_nxt;
      window_timer_r  <= window_timer_nxt;
      start_freq_r    <= start_freq_nxt;
      spin_timer_r    <= spin_timer_nxt;
      spin_cnt_r      <= spin_cnt_nxt;
      fail_r          <= fail_nxt;
      out_valid_r     <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_code_r <= fail_nxt;
    end
  end

  a_fail_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (fail_r != FAIL_NONE) |=> (fail_r != FAIL_NONE))
    else $error("failure code cleared without reset");

  a_fail_range: assert property (@(posedge clk) disable iff (!rst_n)
    fail_r <= FAIL_SPIN_DANGER)
    else $error("failure code out of range");

  a_timer_bound: assert property (@(posedge clk) disable iff (!rst_n)
    !blocked_timer_r[TIMER_W-1] && !window_timer_r[TIMER_W-1] && !spin_timer_r[TIMER_W-1])
    else $error("timer left its 20-bit range");

  a_pop_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> out_valid_r)
    else $error("result not presented after command taken");

endmodule

// ----- rtl/drain_fault_monitor.sv -----
// Top level: drain fault monitor, front end, command queue and back end.
// Each accepted tick yields exactly one transaction on the out_ channel carrying the sticky
// failure code after that tick. The block sustains one tick per clock cycle while the result
// side is not stalled; a tick is first written into the two-entry command queue, then the back
// end's timer update writes its result into the result register. The rate is set by the back
// end, which updates the timers, the window baseline, the spin counter and the failure state
// that a tick touches. Configuration writes through cfg_we/cfg_index/cfg_data take effect on
// the next cycle and must only be issued while no tick is in flight.
`timescale 1ns / 1ps
module drain_fault_monitor
  import dfm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [MODE_W-1:0]    in_mode,
  input  logic [PERIOD_W-1:0]  in_period_ms,
  input  logic                 in_level_flag,
  input  logic [FREQ_W-1:0]    in_level_freq,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [FAIL_W-1:0]    out_failure_code
);

  logic q_valid;
  cmd_t q_cmd;
  logic q_pop;

  dfm_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_mode       (in_mode),
    .in_period_ms  (in_period_ms),
    .in_level_flag (in_level_flag),
    .in_level_freq (in_level_freq),
    .q_valid       (q_valid),
    .q_cmd         (q_cmd),
    .q_pop         (q_pop)
  );

  dfm_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .q_valid          (q_valid),
    .q_cmd            (q_cmd),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_failure_code (out_failure_code)
  );

endmodule
